// ===== rtl/rss_pkg.sv =====
package rss_pkg;

   localparam int SUM_WIDTH = 64;
   localparam int STEP_WIDTH = $clog2(SUM_WIDTH);
   localparam int MODE_WIDTH = 4;
   localparam int THRESHOLD_WIDTH = 32;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THRESHOLD = 1'b1;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_PASS      = 4'd0,
      MODE_MAX       = 4'd1,
      MODE_MIN       = 4'd2,
      MODE_AVERAGE   = 4'd3,
      MODE_SUM       = 4'd4,
      MODE_FINAL     = 4'd5,
      MODE_IDX_MAX   = 4'd6,
      MODE_IDX_MIN   = 4'd7,
      MODE_THRESHOLD = 4'd8
   } mode_type;

   typedef enum logic [3:0] {
      OP_PASS,
      OP_MAX,
      OP_MIN,
      OP_AVG,
      OP_SUM,
      OP_IDX_MAX,
      OP_IDX_MIN,
      OP_THRESHOLD,
      OP_NONE
   } op_type;

   typedef struct packed {
      logic   clear_first;
      op_type op;
   } ctrl_type;

endpackage

// ===== rtl/rss_front.sv =====
module rss_front #(
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_push,
   output logic                                         req_full,
   input  logic signed [SAMPLE_WIDTH-1:0]               req_sample,
   input  logic                                         req_clear_first,
   input  logic                                         csr_we,
   input  logic [rss_pkg::CSR_INDEX_WIDTH-1:0]          csr_index,
   input  logic [rss_pkg::CSR_DATA_WIDTH-1:0]           csr_wdata,
   output logic signed [rss_pkg::THRESHOLD_WIDTH-1:0]   threshold,
   output logic                                         q_valid,
   input  logic                                         q_pop,
   output logic signed [SAMPLE_WIDTH-1:0]               q_sample,
   output rss_pkg::ctrl_type                            q_ctrl
);

   localparam int DEPTH = 2;

   logic [rss_pkg::MODE_WIDTH-1:0]              mode_ff;
   logic signed [rss_pkg::THRESHOLD_WIDTH-1:0]  threshold_ff;
   logic signed [SAMPLE_WIDTH-1:0]              sample_ff [DEPTH];
   rss_pkg::ctrl_type                           ctrl_ff [DEPTH];
   logic                                        wr_ptr_ff;
   logic                                        rd_ptr_ff;
   logic [1:0]                                  count_ff;
   logic [1:0]                                  count_in;
   logic                                        push_ok;
   logic                                        pop_ok;
   rss_pkg::op_type                             op;

   // mode decode into the operation the back end carries out
   always_comb begin
      unique case (mode_ff)
         rss_pkg::MODE_PASS, rss_pkg::MODE_FINAL: op = rss_pkg::OP_PASS;
         rss_pkg::MODE_MAX:       op = rss_pkg::OP_MAX;
         rss_pkg::MODE_MIN:       op = rss_pkg::OP_MIN;
         rss_pkg::MODE_AVERAGE:   op = rss_pkg::OP_AVG;
         rss_pkg::MODE_SUM:       op = rss_pkg::OP_SUM;
         rss_pkg::MODE_IDX_MAX:   op = rss_pkg::OP_IDX_MAX;
         rss_pkg::MODE_IDX_MIN:   op = rss_pkg::OP_IDX_MIN;
         rss_pkg::MODE_THRESHOLD: op = rss_pkg::OP_THRESHOLD;
         default:                 op = rss_pkg::OP_NONE;
      endcase
   end

   assign req_full  = (count_ff == 2'(DEPTH));
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = q_pop && q_valid;
   assign q_valid   = (count_ff != 2'd0);
   assign q_sample  = sample_ff[rd_ptr_ff];
   assign q_ctrl    = ctrl_ff[rd_ptr_ff];
   assign threshold = threshold_ff;

   always_comb begin
      count_in = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 2'd1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= '0;
         threshold_ff <= '0;
         wr_ptr_ff    <= 1'b0;
         rd_ptr_ff    <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               rss_pkg::CSR_MODE:      mode_ff <= csr_wdata[rss_pkg::MODE_WIDTH-1:0];
               rss_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (push_ok) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop_ok) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         sample_ff[wr_ptr_ff]      <= req_sample;
         ctrl_ff[wr_ptr_ff].clear_first <= req_clear_first;
         ctrl_ff[wr_ptr_ff].op     <= op;
      end
   end

endmodule

// ===== rtl/rss_div.sv =====
module rss_div #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [rss_pkg::SUM_WIDTH-1:0]         magnitude,
   input  logic                                  negate,
   input  logic [COUNT_WIDTH-1:0]                divisor,
   output logic                                  done,
   output logic signed [rss_pkg::SUM_WIDTH-1:0]  quotient
);

   logic                                busy_ff;
   logic                                done_ff;
   logic                                neg_ff;
   logic [rss_pkg::STEP_WIDTH-1:0]      step_ff;
   logic [COUNT_WIDTH-1:0]              rem_ff;
   logic [COUNT_WIDTH-1:0]              rem_in;
   logic [COUNT_WIDTH-1:0]              div_ff;
   logic [rss_pkg::SUM_WIDTH-1:0]       quo_ff;
   logic [COUNT_WIDTH:0]                shifted;
   logic [COUNT_WIDTH:0]                diff;
   logic                                fits;

   // restoring division, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[rss_pkg::SUM_WIDTH-1]};
      diff    = shifted - {1'b0, div_ff};
      fits    = (shifted >= {1'b0, div_ff});
      rem_in  = fits ? diff[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == rss_pkg::STEP_WIDTH'(rss_pkg::SUM_WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= magnitude;
         div_ff <= divisor;
         neg_ff <= negate;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[rss_pkg::SUM_WIDTH-2:0], fits};
      end
   end

endmodule

// ===== rtl/rss_back.sv =====
module rss_back #(
   parameter int SAMPLE_WIDTH = 32,
   parameter int COUNT_WIDTH  = 32
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic signed [rss_pkg::THRESHOLD_WIDTH-1:0]   threshold,
   input  logic                                         q_valid,
   output logic                                         q_pop,
   input  logic signed [SAMPLE_WIDTH-1:0]               q_sample,
   input  rss_pkg::ctrl_type                            q_ctrl,
   output logic                                         rsp_empty,
   input  logic                                         rsp_pop,
   output logic signed [rss_pkg::SUM_WIDTH-1:0]         rsp_summary_value
);

   localparam int SW  = rss_pkg::SUM_WIDTH;
   localparam int CMP_WIDTH = (SAMPLE_WIDTH > rss_pkg::THRESHOLD_WIDTH) ?
                              SAMPLE_WIDTH : rss_pkg::THRESHOLD_WIDTH;
   localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

   typedef enum logic {ST_IDLE, ST_DIV} state_type;

   state_type                        state_ff;
   logic [COUNT_WIDTH-1:0]           count_ff;
   logic signed [SAMPLE_WIDTH-1:0]   extreme_ff;
   logic signed [SW-1:0]             sum_ff;
   logic signed [SW-1:0]             held_ff;
   logic signed [SAMPLE_WIDTH-1:0]   prev_ff;
   logic                             have_prev_ff;
   logic                             crossed_ff;
   logic                             out_valid_ff;
   logic signed [SW-1:0]             out_value_ff;

   logic [COUNT_WIDTH-1:0]           cnt0, count_in;
   logic signed [SAMPLE_WIDTH-1:0]   ext0, extreme_in;
   logic signed [SW-1:0]             sum0, sum_in;
   logic signed [SW-1:0]             held0, held_in;
   logic signed [SAMPLE_WIDTH-1:0]   prev0, prev_in;
   logic                             hp0, have_prev_in;
   logic                             cr0, crossed_in;
   logic signed [SW:0]               sum_wide;
   logic signed [SW-1:0]             sum_sat;
   logic signed [SW-1:0]             x_ext;
   logic signed [SW-1:0]             idx;
   logic signed [CMP_WIDTH-1:0]      x_c, prev_c, thr_c;
   logic                             crossing;
   logic                             take;
   logic                             div_start;
   logic                             div_done;
   logic [SW-1:0]                    div_mag;
   logic signed [SW-1:0]             div_quot;

   assign take      = q_valid && (state_ff == ST_IDLE) && (!out_valid_ff || rsp_pop);
   assign q_pop     = take;
   assign div_start = take && (q_ctrl.op == rss_pkg::OP_AVG);
   assign rsp_empty = !out_valid_ff;
   assign rsp_summary_value = out_value_ff;

   always_comb begin
      cnt0  = count_ff;
      ext0  = extreme_ff;
      sum0  = sum_ff;
      held0 = held_ff;
      prev0 = prev_ff;
      hp0   = have_prev_ff;
      cr0   = crossed_ff;
      if (q_ctrl.clear_first) begin
         cnt0  = '0;
         sum0  = '0;
         held0 = '0;
         prev0 = '0;
         hp0   = 1'b0;
         cr0   = 1'b0;
         ext0  = (q_ctrl.op == rss_pkg::OP_MIN || q_ctrl.op == rss_pkg::OP_IDX_MIN) ?
                 SMAX : SMIN;
      end

      count_in = (cnt0 == '1) ? cnt0 : cnt0 + COUNT_WIDTH'(1);
      x_ext    = SW'(q_sample);
      idx      = SW'(count_in);

      sum_wide = (SW+1)'(sum0) + (SW+1)'(x_ext);
      if (sum_wide[SW] != sum_wide[SW-1]) begin
         sum_sat = sum_wide[SW] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_wide[SW-1:0];
      end

      x_c      = CMP_WIDTH'(q_sample);
      prev_c   = CMP_WIDTH'(prev0);
      thr_c    = CMP_WIDTH'(threshold);
      crossing = (prev_c < thr_c && thr_c <= x_c) || (prev_c > thr_c && thr_c >= x_c);

      extreme_in   = ext0;
      sum_in       = sum0;
      held_in      = held0;
      prev_in      = prev0;
      have_prev_in = hp0;
      crossed_in   = cr0;

      unique case (q_ctrl.op)
         rss_pkg::OP_PASS: held_in = x_ext;
         rss_pkg::OP_MAX, rss_pkg::OP_IDX_MAX: begin
            if (q_sample > ext0) begin
               extreme_in = q_sample;
               held_in    = (q_ctrl.op == rss_pkg::OP_MAX) ? x_ext : idx;
            end
         end
         rss_pkg::OP_MIN, rss_pkg::OP_IDX_MIN: begin
            if (q_sample < ext0) begin
               extreme_in = q_sample;
               held_in    = (q_ctrl.op == rss_pkg::OP_MIN) ? x_ext : idx;
            end
         end
         rss_pkg::OP_AVG: sum_in = sum_sat;
         rss_pkg::OP_SUM: begin
            sum_in  = sum_sat;
            held_in = sum_sat;
         end
         rss_pkg::OP_THRESHOLD: begin
            if (!cr0) begin
               prev_in      = q_sample;
               have_prev_in = 1'b1;
               if (hp0) begin
                  crossed_in = crossing;
                  if (crossing) begin
                     held_in = idx;
                  end
               end
            end
         end
         default: ;
      endcase

      div_mag = sum_sat[SW-1] ? SW'(-sum_sat) : SW'(sum_sat);
   end

   rss_div #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .magnitude (div_mag),
      .negate    (sum_sat[SW-1]),
      .divisor   (count_in),
      .done      (div_done),
      .quotient  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         extreme_ff   <= SMIN;
         sum_ff       <= '0;
         held_ff      <= '0;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         crossed_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         out_value_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  count_ff     <= count_in;
                  extreme_ff   <= extreme_in;
                  sum_ff       <= sum_in;
                  held_ff      <= held_in;
                  prev_ff      <= prev_in;
                  have_prev_ff <= have_prev_in;
                  crossed_ff   <= crossed_in;
                  if (div_start) begin
                     out_valid_ff <= 1'b0;
                     state_ff     <= ST_DIV;
                  end else begin
                     out_valid_ff <= 1'b1;
                     out_value_ff <= held_in;
                  end
               end else if (rsp_pop) begin
                  out_valid_ff <= 1'b0;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  held_ff      <= div_quot;
                  out_value_ff <= div_quot;
                  out_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/running_summary_statistic.sv =====
// channel  | ports                                        | handshake
// request  | req_sample, req_clear_first                  | req_push / req_full
// response | rsp_summary_value                            | rsp_empty / rsp_pop
// csr      | csr_index, csr_wdata                         | csr_we
//
// Outside average a word goes through the queue and then the result register;
// one word a cycle in every mode but average while results are popped. Average waits on
// the one-bit-a-cycle back-end restoring divider; no new word enters until it is done.
// Two-deep queue between front and back; one-word result register.
// Synchronous reset; state as after a clear, mode and threshold zero.
module running_summary_statistic #(
   parameter int SAMPLE_WIDTH = 32,
   parameter int COUNT_WIDTH  = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_sample,
   input  logic                                   req_clear_first,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic signed [rss_pkg::SUM_WIDTH-1:0]   rsp_summary_value,
   input  logic                                   csr_we,
   input  logic [rss_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [rss_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   logic signed [rss_pkg::THRESHOLD_WIDTH-1:0]  threshold;
   logic                                        q_valid;
   logic                                        q_pop;
   logic signed [SAMPLE_WIDTH-1:0]              q_sample;
   rss_pkg::ctrl_type                           q_ctrl;

   rss_front #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_sample      (req_sample),
      .req_clear_first (req_clear_first),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .threshold       (threshold),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_sample        (q_sample),
      .q_ctrl          (q_ctrl)
   );

   rss_back #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .threshold         (threshold),
      .q_valid           (q_valid),
      .q_pop             (q_pop),
      .q_sample          (q_sample),
      .q_ctrl            (q_ctrl),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_summary_value (rsp_summary_value)
   );

endmodule

// ===== rtl/rss_checker.sv =====
module rss_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_push,
   input logic                                 req_full,
   input logic                                 rsp_empty,
   input logic                                 rsp_pop,
   input logic [rss_pkg::SUM_WIDTH-1:0]        rsp_summary_value
);

   logic [2:0] pending_ff;
   logic [2:0] pending_in;
   logic       push_ok;
   logic       pop_ok;

   assign push_ok = req_push && !req_full;
   assign pop_ok  = rsp_pop && !rsp_empty;

   always_comb begin
      pending_in = pending_ff;
      if (push_ok && !pop_ok) begin
         pending_in = pending_ff + 3'd1;
      end else if (pop_ok && !push_ok) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queue not empty after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 3'd0 |-> rsp_empty)
      else $error("result word with no word outstanding");

   a_last_drained: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 3'd1 && pop_ok && !push_ok |=> rsp_empty)
      else $error("result word after last word taken");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_summary_value))
      else $error("result word changed while waiting");

endmodule

bind running_summary_statistic rss_checker u_rss_checker (
   .clock             (clock),
   .reset             (reset),
   .req_push          (req_push),
   .req_full          (req_full),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_summary_value (rsp_summary_value)
);

// ===== verif/running_summary_statistic_test.sv =====
`timescale 1ns / 100ps

module running_summary_statistic_test;

   localparam logic [rss_pkg::MODE_WIDTH-1:0] MODE_LAST = 4'hF;
   localparam logic signed [31:0] SAMPLE_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] SAMPLE_MIN = 32'sh8000_0000;
   localparam longint COUNT_CEIL = 64'sd4294967295;
   localparam longint SUM_MAX = 64'sh7fff_ffff_ffff_ffff;
   localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;
   localparam int QUIET_LIMIT = 5000;
   localparam int REPORT_LIMIT = 10;
   localparam int IDLE_PCT = 36;

   logic clock = 1'b0;
   logic reset;
   logic req_push;
   logic req_full;
   logic signed [31:0] req_sample;
   logic req_clear_first;
   logic rsp_empty;
   logic rsp_pop;
   logic signed [rss_pkg::SUM_WIDTH-1:0] rsp_summary_value;
   logic csr_we;
   logic [rss_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [rss_pkg::CSR_DATA_WIDTH-1:0] csr_wdata;

   // predicted block state
   logic [rss_pkg::MODE_WIDTH-1:0] model_mode;
   logic signed [31:0] model_threshold;
   longint run_count;
   longint run_extreme;
   longint run_sum;
   longint held_summary;
   longint prev_sample;
   logic have_prev;
   logic crossed_flag;

   longint summary_queue[$];
   longint next_summary;
   int mismatch_count = 0;
   int quiet_cycles = 0;
   int send_idle_pct = IDLE_PCT;
   int take_idle_pct = IDLE_PCT;

   running_summary_statistic dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_sample(req_sample),
      .req_clear_first(req_clear_first),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_summary_value(rsp_summary_value),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic void clear_run_state();
      run_count = 0;
      run_sum = 0;
      held_summary = 0;
      prev_sample = 0;
      have_prev = 1'b0;
      crossed_flag = 1'b0;
      if (model_mode == rss_pkg::MODE_MIN || model_mode == rss_pkg::MODE_IDX_MIN) begin
         run_extreme = longint'(SAMPLE_MAX);
      end else begin
         run_extreme = longint'(SAMPLE_MIN);
      end
   endfunction

   function automatic longint saturating_add(longint acc, longint x);
      if (x > 0 && acc > SUM_MAX - x) return SUM_MAX;
      if (x < 0 && acc < SUM_MIN - x) return SUM_MIN;
      return acc + x;
   endfunction

   function automatic longint predict_summary(logic signed [31:0] s, logic clr);
      longint x;
      longint thr;
      x = longint'(s);
      thr = longint'(model_threshold);
      if (clr) clear_run_state();
      if (run_count < COUNT_CEIL) run_count++;
      case (model_mode)
         rss_pkg::MODE_PASS, rss_pkg::MODE_FINAL: begin
            held_summary = x;
         end
         rss_pkg::MODE_MAX: begin
            if (x > run_extreme) begin
               run_extreme = x;
               held_summary = x;
            end
         end
         rss_pkg::MODE_MIN: begin
            if (x < run_extreme) begin
               run_extreme = x;
               held_summary = x;
            end
         end
         rss_pkg::MODE_AVERAGE: begin
            run_sum = saturating_add(run_sum, x);
            held_summary = run_sum / run_count;
         end
         rss_pkg::MODE_SUM: begin
            run_sum = saturating_add(run_sum, x);
            held_summary = run_sum;
         end
         rss_pkg::MODE_IDX_MAX: begin
            if (x > run_extreme) begin
               run_extreme = x;
               held_summary = run_count;
            end
         end
         rss_pkg::MODE_IDX_MIN: begin
            if (x < run_extreme) begin
               run_extreme = x;
               held_summary = run_count;
            end
         end
         rss_pkg::MODE_THRESHOLD: begin
            if (!crossed_flag) begin
               if (!have_prev) begin
                  prev_sample = x;
                  have_prev = 1'b1;
               end else begin
                  crossed_flag = (prev_sample < thr && thr <= x) ||
                                 (prev_sample > thr && thr >= x);
                  prev_sample = x;
                  if (crossed_flag) held_summary = run_count;
               end
            end
         end
         default: begin
         end
      endcase
      return held_summary;
   endfunction

   function automatic logic signed [31:0] random_sample();
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0: return SAMPLE_MIN;
               1: return SAMPLE_MAX;
               2: return '0;
               default: return -1;
            endcase
         end
         1, 2, 3: return model_threshold + 32'($urandom_range(8)) - 32'd4;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(logic signed [31:0] s, logic clr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_sample <= s;
      req_clear_first <= clr;
      @(posedge clock);
      while (req_full) @(posedge clock);
      summary_queue.push_back(predict_summary(s, clr));
   endtask

   // drain every outstanding word, then let the back end go quiet
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (summary_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(logic [rss_pkg::MODE_WIDTH-1:0] m, logic signed [31:0] t);
      csr_we <= 1'b1;
      csr_index <= rss_pkg::CSR_MODE;
      csr_wdata <= rss_pkg::CSR_DATA_WIDTH'(m);
      @(posedge clock);
      csr_index <= rss_pkg::CSR_THRESHOLD;
      csr_wdata <= t;
      @(posedge clock);
      csr_we <= 1'b0;
      model_mode = m;
      model_threshold = t;
   endtask

   task automatic test_directed_cases();
      configure(rss_pkg::MODE_PASS, '0);
      send_word(SAMPLE_MAX, 1'b1);
      send_word(SAMPLE_MIN, 1'b0);
      settle();
      // sample equal to the reset extreme must not register
      configure(rss_pkg::MODE_MAX, '0);
      send_word(SAMPLE_MIN, 1'b1);
      send_word(32'sd5, 1'b0);
      send_word(32'sd3, 1'b0);
      send_word(SAMPLE_MIN, 1'b1);
      settle();
      // min mode on top of max-mode clear state never finds a smaller value
      configure(rss_pkg::MODE_MIN, '0);
      send_word(-32'sd7, 1'b0);
      send_word(SAMPLE_MAX, 1'b1);
      send_word(-32'sd1, 1'b0);
      settle();
      // negative average truncates toward zero
      configure(rss_pkg::MODE_AVERAGE, '0);
      send_word(-32'sd3, 1'b1);
      send_word(-32'sd2, 1'b0);
      send_word(SAMPLE_MAX, 1'b0);
      settle();
      configure(rss_pkg::MODE_SUM, '0);
      send_word(SAMPLE_MIN, 1'b1);
      send_word(SAMPLE_MIN, 1'b0);
      settle();
      configure(rss_pkg::MODE_FINAL, '0);
      send_word(32'sd42, 1'b0);
      settle();
      configure(rss_pkg::MODE_IDX_MAX, '0);
      send_word(32'sd1, 1'b1);
      send_word(32'sd1, 1'b0);
      send_word(32'sd4, 1'b0);
      settle();
      configure(rss_pkg::MODE_IDX_MIN, '0);
      send_word(32'sd9, 1'b1);
      send_word(-32'sd9, 1'b0);
      settle();
      // upward crossing landing on the level, then frozen; then downward
      configure(rss_pkg::MODE_THRESHOLD, 32'sh0001_0000);
      send_word('0, 1'b1);
      send_word(32'sh0001_0000, 1'b0);
      send_word(-32'sd5, 1'b0);
      send_word(32'sh0002_0000, 1'b1);
      send_word(32'sh0003_0000, 1'b0);
      send_word(32'sh0001_0000, 1'b0);
      settle();
      configure(MODE_LAST, SAMPLE_MIN);
      send_word(32'sd7, 1'b0);
      settle();
   endtask

   task automatic test_random_phases(int words);
      int sent;
      int run_len;
      logic [rss_pkg::MODE_WIDTH-1:0] m;
      logic signed [31:0] t;
      logic clr;
      sent = 0;
      while (sent < words) begin
         settle();
         if ($urandom_range(9) == 0) begin
            m = rss_pkg::MODE_WIDTH'($urandom_range(int'(MODE_LAST),
                                                    int'(rss_pkg::MODE_THRESHOLD) + 1));
         end else begin
            m = rss_pkg::MODE_WIDTH'($urandom_range(int'(rss_pkg::MODE_THRESHOLD)));
         end
         case ($urandom_range(4))
            0: t = SAMPLE_MIN;
            1: t = SAMPLE_MAX;
            2: t = '0;
            3: t = $urandom;
            default: t = 32'($urandom_range(64)) - 32'd32;
         endcase
         configure(m, t);
         run_len = $urandom_range(60, 8);
         for (int i = 0; i < run_len; i++) begin
            if (i == 0) begin
               clr = 1'($urandom_range(1));
            end else begin
               clr = ($urandom_range(model_mode == rss_pkg::MODE_THRESHOLD ? 5 : 15) == 0);
            end
            send_word(random_sample(), clr);
         end
         sent += run_len;
      end
      settle();
   endtask

   task automatic test_unbroken_stream();
      send_idle_pct = 0;
      take_idle_pct = 0;
      for (int p = 0; p < 3; p++) begin
         configure(rss_pkg::MODE_WIDTH'($urandom_range(int'(rss_pkg::MODE_THRESHOLD))),
                   $urandom);
         for (int i = 0; i < 80; i++) begin
            send_word(random_sample(), ($urandom_range(15) == 0));
         end
         settle();
      end
      send_idle_pct = IDLE_PCT;
      take_idle_pct = IDLE_PCT;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (summary_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("word with nothing expected: got %0d", rsp_summary_value);
               end
            end else begin
               next_summary = summary_queue.pop_front();
               if (rsp_summary_value !== next_summary) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("summary mismatch: expected %0d, got %0d",
                              next_summary, rsp_summary_value);
                  end
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("running_summary_statistic_test: errors");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_push <= 1'b0;
      req_sample <= '0;
      req_clear_first <= 1'b0;
      rsp_pop <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= rss_pkg::CSR_MODE;
      csr_wdata <= '0;
      model_mode = rss_pkg::MODE_PASS;
      model_threshold = '0;
      clear_run_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_phases(1400);
      test_unbroken_stream();
      settle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && summary_queue.size() == 0) begin
         $display("running_summary_statistic_test: clean");
      end else begin
         $display("running_summary_statistic_test: errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rss_pkg.sv
rtl/rss_front.sv
rtl/rss_div.sv
rtl/rss_back.sv
rtl/running_summary_statistic.sv
rtl/rss_checker.sv
verif/running_summary_statistic_test.sv
